// File: rtl/core/wmdd_pkg.sv
// ----------------------------------------------------------------------------
// wmdd_pkg: shared definitions for the wheel momentum dump dipole core
// Field widths, register codes, sequencer states and operation steps.
// ----------------------------------------------------------------------------
`default_nettype none

package wmdd_pkg;

  localparam int VALUE_BITS   = 24;
  localparam int SUM_BITS     = VALUE_BITS + 3;
  localparam int LIMIT_BITS   = VALUE_BITS - 1;
  localparam int KP_BITS      = 16;
  localparam int DIP_BITS     = 32;
  localparam int LEN_BITS     = 2 * VALUE_BITS;
  localparam int CROSS_BITS   = VALUE_BITS + SUM_BITS + 1;
  localparam int MUL_A_BITS   = CROSS_BITS - 1;
  localparam int MUL_B_BITS   = VALUE_BITS;
  localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int NUM_BITS     = MUL_A_BITS + KP_BITS;
  localparam int DEN_BITS     = LEN_BITS;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = LIMIT_BITS;

  localparam logic [LIMIT_BITS-1:0] UPPER_RST = LIMIT_BITS'(7549747);
  localparam logic [LIMIT_BITS-1:0] LOWER_RST = LIMIT_BITS'(838861);
  localparam logic [KP_BITS-1:0]    GAIN_RST  = KP_BITS'(6554);

  localparam logic [DIP_BITS-1:0] DIP_MAX = {1'b0, {(DIP_BITS-1){1'b1}}};
  localparam logic [DIP_BITS-1:0] DIP_MIN = {1'b1, {(DIP_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_UPPER = 2'd0,
    CFG_LOWER = 2'd1,
    CFG_GAIN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_HX, OP_HY, OP_HZ, OP_UP, OP_LO,
    OP_BX, OP_BY, OP_BZ,
    OP_C0A, OP_C0B, OP_C1A, OP_C1B, OP_C2A, OP_C2B,
    OP_K0, OP_K1, OP_K2
  } op_e;

endpackage

`default_nettype wire

// File: rtl/core/wmdd_if.sv
// ----------------------------------------------------------------------------
// wmdd_if: request channels of the wheel momentum dump dipole core
// Wheel request channel in, dipole request channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmdd_in_if;
  import wmdd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] wheel_hx;
  logic signed [VALUE_BITS-1:0] wheel_hy;
  logic signed [VALUE_BITS-1:0] wheel_hz;
  logic signed [VALUE_BITS-1:0] field_bx;
  logic signed [VALUE_BITS-1:0] field_by;
  logic signed [VALUE_BITS-1:0] field_bz;
  logic                         last_wheel;

  modport source(output valid, wheel_hx, wheel_hy, wheel_hz, field_bx, field_by, field_bz,
                 last_wheel, input ready);
  modport sink(input valid, wheel_hx, wheel_hy, wheel_hz, field_bx, field_by, field_bz,
               last_wheel, output ready);
endinterface

interface wmdd_out_if;
  import wmdd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [DIP_BITS-1:0] dipole_x;
  logic signed [DIP_BITS-1:0] dipole_y;
  logic signed [DIP_BITS-1:0] dipole_z;
  logic                       any_saturated;
  logic                       any_below_lower;
  logic                       weak_field;

  modport source(output valid, dipole_x, dipole_y, dipole_z, any_saturated,
                 any_below_lower, weak_field, input ready);
  modport sink(input valid, dipole_x, dipole_y, dipole_z, any_saturated,
               any_below_lower, weak_field, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wmdd_mul.sv
// ----------------------------------------------------------------------------
// wmdd_mul: bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle; product holds until next start.
// ----------------------------------------------------------------------------
`default_nettype none

module wmdd_mul (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [wmdd_pkg::MUL_A_BITS-1:0]    a_i,
  input  wire logic [wmdd_pkg::MUL_B_BITS-1:0]    b_i,
  output logic                                    done_o,
  output logic [wmdd_pkg::MUL_P_BITS-1:0]         prod_o
);
  import wmdd_pkg::*;

  localparam int CNT_BITS = $clog2(MUL_B_BITS + 1);
  localparam int HI_BITS  = MUL_A_BITS + 1;

  logic [CNT_BITS-1:0]           cnt_q;
  logic                          done_q;
  logic [HI_BITS+MUL_B_BITS-1:0] acc_q, acc_d;
  logic [MUL_A_BITS-1:0]         a_q;
  logic [HI_BITS-1:0]            hi_sum;

  always_comb begin
    hi_sum = acc_q[HI_BITS+MUL_B_BITS-1:MUL_B_BITS]
           + (acc_q[0] ? {1'b0, a_q} : '0);
    acc_d  = {1'b0, hi_sum, acc_q[MUL_B_BITS-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_BITS'(1));
      if (start_i) begin
        cnt_q <= CNT_BITS'(MUL_B_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{HI_BITS{1'b0}}, b_i};
      a_q   <= a_i;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[MUL_P_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/core/wmdd_div.sv
// ----------------------------------------------------------------------------
// wmdd_div: restoring divider
// One quotient bit per cycle; quotient shifts in as the numerator shifts out.
// ----------------------------------------------------------------------------
`default_nettype none

module wmdd_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [wmdd_pkg::NUM_BITS-1:0]    num_i,
  input  wire logic [wmdd_pkg::DEN_BITS-1:0]    den_i,
  output logic                                  done_o,
  output logic [wmdd_pkg::NUM_BITS-1:0]         quo_o
);
  import wmdd_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [CNT_BITS-1:0] cnt_q;
  logic                done_q;
  logic [NUM_BITS-1:0] n_q;
  logic [DEN_BITS-1:0] r_q, d_q, r_d;
  logic [DEN_BITS:0]   r_sh;
  logic                ge;

  always_comb begin
    r_sh = {r_q, n_q[NUM_BITS-1]};
    ge   = (r_sh >= {1'b0, d_q});
    r_d  = ge ? DEN_BITS'(r_sh - {1'b0, d_q}) : r_sh[DEN_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_BITS'(1));
      if (start_i) begin
        cnt_q <= CNT_BITS'(NUM_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (cnt_q != '0) begin
      n_q <= {n_q[NUM_BITS-2:0], ge};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

`default_nettype wire

// File: rtl/core/wheel_momentum_dump_dipole_core.sv
// ----------------------------------------------------------------------------
// wheel_momentum_dump_dipole_core: magnetorquer dipole for wheel desaturation
// Sums wheel momenta, flags wheels outside limits, emits (B x -kp*H)/|B|^2.
// ----------------------------------------------------------------------------
//   channel  | dir | contents
//   in_i     | in  | wheel momentum, field, last_wheel marker
//   out_o    | out | dipole x/y/z, saturated, below lower, weak field
//   cfg      | in  | upper limit, lower limit, gain
//
// Each wheel request runs five squares through the bit-serial multiplier.
// The last wheel adds three field squares, six cross terms, then per axis a
// gain multiply and a divide; a zero field square sum goes straight to emit.
// No clearing pass follows reset. A result that is not taken holds the
// sequencer before it loads the next one.
`default_nettype none

module wheel_momentum_dump_dipole_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [wmdd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [wmdd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  wmdd_in_if.sink                                  in_i,
  wmdd_out_if.source                               out_o
);
  import wmdd_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [LIMIT_BITS-1:0] upper_q, lower_q;
  logic [KP_BITS-1:0]    gain_q;

  logic signed [SUM_BITS-1:0] sum_q [3];
  logic signed [SUM_BITS-1:0] sum_new [3];
  logic [SUM_BITS-1:0]        hsum_mag [3];
  logic [2:0]                 hsum_neg;
  logic signed [VALUE_BITS-1:0] in_h [3];
  logic signed [VALUE_BITS-1:0] in_b [3];

  logic [VALUE_BITS-1:0] hmag_q [3];
  logic [VALUE_BITS-1:0] bmag_q [3];
  logic [2:0]            bneg_q;
  logic                  last_q, sat_q, below_q, weak_q;
  logic [LEN_BITS-1:0]   len_q, b2_q, b2_sum;
  logic signed [CROSS_BITS-1:0] cross_q [3];
  logic [MUL_A_BITS-1:0] cmag [3];
  logic [DIP_BITS-1:0]   res_q [3];

  logic                  out_valid_q;
  logic [DIP_BITS-1:0]   odip_q [3];
  logic                  osat_q, obelow_q, oweak_q;

  logic                  in_ready, accept, emit_fire;
  logic                  mul_start, mul_done, div_start, div_done;
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [MUL_P_BITS-1:0] mul_prod;
  logic [NUM_BITS-1:0]   quo;
  logic                  term_neg;
  logic [1:0]            kidx;
  logic signed [CROSS_BITS-1:0] term;
  logic [DIP_BITS-1:0]   dip_sat;
  logic [SUM_BITS:0]     wide [3];

  assign in_h[0] = in_i.wheel_hx;
  assign in_h[1] = in_i.wheel_hy;
  assign in_h[2] = in_i.wheel_hz;
  assign in_b[0] = in_i.field_bx;
  assign in_b[1] = in_i.field_by;
  assign in_b[2] = in_i.field_bz;

  // saturating running sum, magnitudes of the current sum and of the cross terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {sum_q[i][SUM_BITS-1], sum_q[i]}
              + {{(SUM_BITS-VALUE_BITS+1){in_h[i][VALUE_BITS-1]}}, in_h[i]};
      if (wide[i][SUM_BITS] != wide[i][SUM_BITS-1]) begin
        sum_new[i] = wide[i][SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                       : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
        sum_new[i] = wide[i][SUM_BITS-1:0];
      end
      hsum_neg[i] = sum_q[i][SUM_BITS-1];
      hsum_mag[i] = hsum_neg[i] ? SUM_BITS'(-sum_q[i]) : SUM_BITS'(sum_q[i]);
      cmag[i]     = cross_q[i][CROSS_BITS-1] ? MUL_A_BITS'(-cross_q[i])
                                             : MUL_A_BITS'(cross_q[i]);
    end
  end

  // operand select for each step
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    term_neg = 1'b0;
    kidx     = 2'd0;
    case (op_q)
      OP_HX: begin mul_a = MUL_A_BITS'(hmag_q[0]); mul_b = hmag_q[0]; end
      OP_HY: begin mul_a = MUL_A_BITS'(hmag_q[1]); mul_b = hmag_q[1]; end
      OP_HZ: begin mul_a = MUL_A_BITS'(hmag_q[2]); mul_b = hmag_q[2]; end
      OP_UP: begin mul_a = MUL_A_BITS'(upper_q); mul_b = MUL_B_BITS'(upper_q); end
      OP_LO: begin mul_a = MUL_A_BITS'(lower_q); mul_b = MUL_B_BITS'(lower_q); end
      OP_BX: begin mul_a = MUL_A_BITS'(bmag_q[0]); mul_b = bmag_q[0]; end
      OP_BY: begin mul_a = MUL_A_BITS'(bmag_q[1]); mul_b = bmag_q[1]; end
      OP_BZ: begin mul_a = MUL_A_BITS'(bmag_q[2]); mul_b = bmag_q[2]; end
      OP_C0A: begin
        mul_a = MUL_A_BITS'(hsum_mag[2]); mul_b = bmag_q[1];
        term_neg = bneg_q[1] ^ hsum_neg[2]; kidx = 2'd0;
      end
      OP_C0B: begin
        mul_a = MUL_A_BITS'(hsum_mag[1]); mul_b = bmag_q[2];
        term_neg = bneg_q[2] ^ hsum_neg[1]; kidx = 2'd0;
      end
      OP_C1A: begin
        mul_a = MUL_A_BITS'(hsum_mag[0]); mul_b = bmag_q[2];
        term_neg = bneg_q[2] ^ hsum_neg[0]; kidx = 2'd1;
      end
      OP_C1B: begin
        mul_a = MUL_A_BITS'(hsum_mag[2]); mul_b = bmag_q[0];
        term_neg = bneg_q[0] ^ hsum_neg[2]; kidx = 2'd1;
      end
      OP_C2A: begin
        mul_a = MUL_A_BITS'(hsum_mag[1]); mul_b = bmag_q[0];
        term_neg = bneg_q[0] ^ hsum_neg[1]; kidx = 2'd2;
      end
      OP_C2B: begin
        mul_a = MUL_A_BITS'(hsum_mag[0]); mul_b = bmag_q[1];
        term_neg = bneg_q[1] ^ hsum_neg[0]; kidx = 2'd2;
      end
      OP_K0: begin mul_a = cmag[0]; mul_b = MUL_B_BITS'(gain_q); kidx = 2'd0; end
      OP_K1: begin mul_a = cmag[1]; mul_b = MUL_B_BITS'(gain_q); kidx = 2'd1; end
      OP_K2: begin mul_a = cmag[2]; mul_b = MUL_B_BITS'(gain_q); kidx = 2'd2; end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign b2_sum = b2_q + mul_prod[LEN_BITS-1:0];
  assign term   = term_neg ? -CROSS_BITS'(mul_prod[CROSS_BITS-3:0])
                           :  CROSS_BITS'(mul_prod[CROSS_BITS-3:0]);

  // dipole sign follows -c; clamp the quotient to 32 bits
  always_comb begin
    if (!cross_q[kidx][CROSS_BITS-1]) begin
      if ((|quo[NUM_BITS-1:DIP_BITS]) || (quo[DIP_BITS-1:0] > DIP_MIN)) begin
        dip_sat = DIP_MIN;
      end else begin
        dip_sat = -quo[DIP_BITS-1:0];
      end
    end else begin
      if (|quo[NUM_BITS-1:DIP_BITS-1]) begin
        dip_sat = DIP_MAX;
      end else begin
        dip_sat = quo[DIP_BITS-1:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    emit_fire = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_MUL;
          op_d    = OP_HX;
        end
      end
      ST_MUL: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (op_q)
            OP_LO: begin
              if (last_q) begin
                op_d = op_e'(5'(op_q) + 5'd1); state_d = ST_MUL;
              end else begin
                state_d = ST_IDLE;
              end
            end
            OP_BZ: begin
              if (b2_sum == '0) begin
                state_d = ST_EMIT;
              end else begin
                op_d = op_e'(5'(op_q) + 5'd1); state_d = ST_MUL;
              end
            end
            OP_K0, OP_K1, OP_K2: begin
              state_d = ST_DIV;
            end
            default: begin
              op_d = op_e'(5'(op_q) + 5'd1); state_d = ST_MUL;
            end
          endcase
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (op_q == OP_K2) begin
            state_d = ST_EMIT;
          end else begin
            op_d = op_e'(5'(op_q) + 5'd1); state_d = ST_MUL;
          end
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          emit_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign accept = in_ready & in_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_HX;
      out_valid_q <= 1'b0;
      sat_q       <= 1'b0;
      below_q     <= 1'b0;
      upper_q     <= UPPER_RST;
      lower_q     <= LOWER_RST;
      gain_q      <= GAIN_RST;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_UPPER: upper_q <= cfg_data_i;
          CFG_LOWER: lower_q <= cfg_data_i;
          CFG_GAIN:  gain_q  <= cfg_data_i[KP_BITS-1:0];
          default:   gain_q  <= gain_q;
        endcase
      end
      if (accept) begin
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_new[i];
        end
      end
      if (state_q == ST_MUL_WAIT && mul_done) begin
        if (op_q == OP_UP && len_q > mul_prod[LEN_BITS-1:0]) begin
          sat_q <= 1'b1;
        end
        if (op_q == OP_LO && len_q < mul_prod[LEN_BITS-1:0]) begin
          below_q <= 1'b1;
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        sat_q       <= 1'b0;
        below_q     <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        hmag_q[i] <= in_h[i][VALUE_BITS-1] ? VALUE_BITS'(-in_h[i]) : VALUE_BITS'(in_h[i]);
        bmag_q[i] <= in_b[i][VALUE_BITS-1] ? VALUE_BITS'(-in_b[i]) : VALUE_BITS'(in_b[i]);
        bneg_q[i] <= in_b[i][VALUE_BITS-1];
      end
      last_q <= in_i.last_wheel;
    end
    if (state_q == ST_MUL_WAIT && mul_done) begin
      case (op_q)
        OP_HX:        len_q <= mul_prod[LEN_BITS-1:0];
        OP_HY, OP_HZ: len_q <= len_q + mul_prod[LEN_BITS-1:0];
        OP_BX: begin
          b2_q   <= mul_prod[LEN_BITS-1:0];
          weak_q <= 1'b0;
        end
        OP_BY: b2_q <= b2_sum;
        OP_BZ: begin
          b2_q   <= b2_sum;
          weak_q <= (b2_sum == '0);
        end
        OP_C0A, OP_C1A, OP_C2A: cross_q[kidx] <= term;
        OP_C0B, OP_C1B, OP_C2B: cross_q[kidx] <= cross_q[kidx] - term;
        default: len_q <= len_q;
      endcase
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      res_q[kidx] <= dip_sat;
    end
    if (emit_fire) begin
      for (int i = 0; i < 3; i++) begin
        odip_q[i] <= weak_q ? '0 : res_q[i];
      end
      osat_q   <= sat_q;
      obelow_q <= below_q;
      oweak_q  <= weak_q;
    end
  end

  wmdd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  wmdd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod[NUM_BITS-1:0]),
    .den_i   (b2_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.dipole_x        = odip_q[0];
  assign out_o.dipole_y        = odip_q[1];
  assign out_o.dipole_z        = odip_q[2];
  assign out_o.any_saturated   = osat_q;
  assign out_o.any_below_lower = obelow_q;
  assign out_o.weak_field      = oweak_q;

endmodule

`default_nettype wire
